@@ rtl/trf_pkg.sv @@
// Shared constants, result word type and byte classification functions for the record framer.
`default_nettype none

package trf_pkg;

    localparam int PAYLOAD_BYTES = 27;
    localparam int CNT_W         = 5;
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] station_id;
        logic       first_of_record;
        logic       last_of_record;
        logic       after_resync;
    } t_result;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ));
    endfunction

    function automatic logic is_tail(input logic [7:0] b);
        return (b == CH_SPACE) || is_letter(b);
    endfunction

    function automatic logic [5:0] station_code(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if ((b >= CH_ONE) && (b <= CH_NINE)) begin
            v = b - CH_ZERO;
        end else if ((b >= CH_UA) && (b <= CH_UZ)) begin
            v = b - CH_UA + LETTER_BASE;
        end else if ((b >= CH_LA) && (b <= CH_LZ)) begin
            v = b - CH_LA + LETTER_BASE;
        end
        return v[5:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/tracker_record_framer_top.sv @@
// Top level of the tracker record framer: framer front end and result queue.
`default_nettype none

// Takes one received byte per cycle whenever full is low; each accepted byte
// passes through the framer with no bubbles, and a payload byte of a good
// record is written into the result queue in the same cycle it is pushed. Header
// bytes, bytes seen while hunting and the records behind a bad header give no
// word. A four-word result queue between the framer and the result ports lets
// the consumer stall; full rises only once that queue holds four words.

module tracker_record_framer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_payload_byte,
    output logic [5:0]      o_station_id,
    output logic            o_first_of_record,
    output logic            o_last_of_record,
    output logic            o_after_resync
);
    import trf_pkg::*;

    logic    w_accept;
    logic    w_wr;
    t_result w_front_word;
    t_result w_out_word;

    assign w_accept = push && !full;

    trf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_byte  (i_rx_byte),
        .o_wr    (w_wr),
        .o_word  (w_front_word)
    );

    trf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_word  (w_front_word),
        .i_rd    (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_word  (w_out_word)
    );

    assign o_payload_byte    = w_out_word.payload_byte;
    assign o_station_id      = w_out_word.station_id;
    assign o_first_of_record = w_out_word.first_of_record;
    assign o_last_of_record  = w_out_word.last_of_record;
    assign o_after_resync    = w_out_word.after_resync;

endmodule

`default_nettype wire

@@ rtl/trf_front.sv @@
// Front end: hunt, header check and payload tagging, one byte per cycle.
`default_nettype none

module trf_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    output logic                  o_wr,
    output trf_pkg::t_result      o_word
);
    import trf_pkg::*;

    localparam logic [2:0] HS_NONE    = 3'd0;
    localparam logic [2:0] HS_CR      = 3'd1;
    localparam logic [2:0] HS_LF      = 3'd2;
    localparam logic [2:0] HS_ZERO    = 3'd3;
    localparam logic [2:0] HS_STATION = 3'd4;

    localparam logic [2:0] HP_CR      = 3'd0;
    localparam logic [2:0] HP_LF      = 3'd1;
    localparam logic [2:0] HP_ZERO    = 3'd2;
    localparam logic [2:0] HP_STATION = 3'd3;
    localparam logic [2:0] HP_TAIL    = 3'd4;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_BYTES - 1);

    logic             r_locked,  n_locked;
    logic [2:0]       r_hunt,    n_hunt;
    logic [2:0]       r_hpos,    n_hpos;
    logic             r_hdr_good, n_hdr_good;
    logic [CNT_W-1:0] r_count,   n_count;
    logic             r_in_pay,  n_in_pay;
    logic [5:0]       r_station, n_station;
    logic             r_by_hunt, n_by_hunt;

    logic       v_last;
    logic       v_matched;
    logic       v_ok;
    logic [2:0] v_hnext;
    logic [5:0] v_code;

    always_comb begin
        n_locked   = r_locked;
        n_hunt     = r_hunt;
        n_hpos     = r_hpos;
        n_hdr_good = r_hdr_good;
        n_count    = r_count;
        n_in_pay   = r_in_pay;
        n_station  = r_station;
        n_by_hunt  = r_by_hunt;
        o_wr       = 1'b0;
        v_matched  = 1'b0;
        v_ok       = 1'b1;
        v_hnext    = HS_NONE;
        v_code     = station_code(i_byte);
        v_last     = (r_count >= LAST_CNT);

        o_word.payload_byte    = i_byte;
        o_word.station_id      = r_station;
        o_word.first_of_record = (r_count == '0);
        o_word.last_of_record  = v_last;
        o_word.after_resync    = r_by_hunt;

        if (i_valid) begin
            if (r_in_pay) begin
                o_wr = r_hdr_good;
                if (v_last) begin
                    n_in_pay   = 1'b0;
                    n_count    = '0;
                    n_hpos     = HP_CR;
                    n_locked   = r_hdr_good;
                    if (!r_hdr_good) begin
                        n_hunt = HS_NONE;
                    end
                    n_hdr_good = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else if (!r_locked) begin
                if ((r_hunt == HS_ZERO) && (i_byte != CH_CR)) begin
                    n_station = v_code;
                end
                if (i_byte == CH_CR) begin
                    v_hnext = HS_CR;
                end else if ((r_hunt == HS_CR) && (i_byte == CH_LF)) begin
                    v_hnext = HS_LF;
                end else if ((r_hunt == HS_LF) && (i_byte == CH_ZERO)) begin
                    v_hnext = HS_ZERO;
                end else if ((r_hunt == HS_ZERO) && (n_station != '0)) begin
                    v_hnext = HS_STATION;
                end else if ((r_hunt == HS_STATION) && is_tail(i_byte)) begin
                    v_matched = 1'b1;
                end
                n_hunt = v_matched ? HS_NONE : v_hnext;
                if (v_matched) begin
                    n_in_pay   = 1'b1;
                    n_count    = '0;
                    n_hdr_good = 1'b1;
                    n_by_hunt  = 1'b1;
                end
            end else begin
                case (r_hpos)
                    HP_CR: begin
                        v_ok = (i_byte == CH_CR);
                    end
                    HP_LF: begin
                        v_ok = (i_byte == CH_LF);
                    end
                    HP_ZERO: begin
                        v_ok = (i_byte == CH_ZERO);
                    end
                    HP_STATION: begin
                        n_station = v_code;
                        v_ok      = (v_code != '0);
                    end
                    default: begin
                        v_ok = is_tail(i_byte);
                    end
                endcase
                if (!v_ok) begin
                    n_hdr_good = 1'b0;
                end
                if (r_hpos >= HP_TAIL) begin
                    n_hpos    = HP_CR;
                    n_in_pay  = 1'b1;
                    n_count   = '0;
                    n_by_hunt = 1'b0;
                end else begin
                    n_hpos = r_hpos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked   <= 1'b0;
            r_hunt     <= HS_NONE;
            r_hpos     <= HP_CR;
            r_hdr_good <= 1'b1;
            r_count    <= '0;
            r_in_pay   <= 1'b0;
            r_station  <= '0;
            r_by_hunt  <= 1'b0;
        end else begin
            r_locked   <= n_locked;
            r_hunt     <= n_hunt;
            r_hpos     <= n_hpos;
            r_hdr_good <= n_hdr_good;
            r_count    <= n_count;
            r_in_pay   <= n_in_pay;
            r_station  <= n_station;
            r_by_hunt  <= n_by_hunt;
        end
    end

    a_hunt_hpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_locked && !r_in_pay) |-> (r_hpos == HP_CR))
        else $error("header position moved while hunting");

    a_word_station: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |-> (r_in_pay && (r_station != '0)))
        else $error("word emitted outside a good record");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pay |-> (r_count <= LAST_CNT))
        else $error("payload counter past record end");

endmodule

`default_nettype wire

@@ rtl/trf_queue.sv @@
// Back end: small result queue that decouples the framer from the consumer.
`default_nettype none

module trf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire trf_pkg::t_result i_word,
    input  wire logic             i_rd,
    output logic                  o_full,
    output logic                  o_empty,
    output trf_pkg::t_result      o_word
);
    import trf_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              v_wr;
    logic              v_rd;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign v_wr    = i_wr && !o_full;
    assign v_rd    = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (v_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (v_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (v_wr && !v_rd) begin
            n_count = r_count + 1'b1;
        end else if (v_rd && !v_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_wr) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("word written into full queue");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("queue full and empty at once");

endmodule

`default_nettype wire

@@ dv/tracker_record_framer_checker.sv @@
// Checker for the tracker record framer: byte-level framing predictor and result word compare.
module tracker_record_framer_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic       i_full,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_empty,
    input  wire logic       i_pop,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic [5:0] i_station_id,
    input  wire logic       i_first_of_record,
    input  wire logic       i_last_of_record,
    input  wire logic       i_after_resync,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_words_checked
);
    import trf_pkg::*;

    typedef enum logic [2:0] {
        HUNT_NONE,
        HUNT_CR,
        HUNT_LF,
        HUNT_ZERO,
        HUNT_STATION
    } t_hunt;

    localparam logic [2:0] HDR_CR      = 3'd0;
    localparam logic [2:0] HDR_LF      = 3'd1;
    localparam logic [2:0] HDR_ZERO    = 3'd2;
    localparam logic [2:0] HDR_STATION = 3'd3;
    localparam logic [2:0] HDR_TAIL    = 3'd4;

    t_result          expected_words[$];
    logic             locked;
    t_hunt            hunt_st;
    logic [2:0]       hdr_pos;
    logic             hdr_ok;
    logic [CNT_W-1:0] pay_cnt;
    logic             in_pay;
    logic [5:0]       station;
    logic             by_hunt;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
    end

    function automatic logic alpha_byte(input logic [7:0] b);
        return ((b >= CH_UA) && (b <= CH_UZ)) || ((b >= CH_LA) && (b <= CH_LZ));
    endfunction

    function automatic logic tail_byte(input logic [7:0] b);
        return (b == CH_SPACE) || alpha_byte(b);
    endfunction

    function automatic logic [5:0] station_of(input logic [7:0] b);
        logic [7:0] code;
        code = 8'd0;
        if ((b >= CH_ONE) && (b <= CH_NINE)) begin
            code = b - CH_ZERO;
        end else if ((b >= CH_UA) && (b <= CH_UZ)) begin
            code = b - CH_UA + LETTER_BASE;
        end else if ((b >= CH_LA) && (b <= CH_LZ)) begin
            code = b - CH_LA + LETTER_BASE;
        end
        return code[5:0];
    endfunction

    task automatic frame_byte(input logic [7:0] b);
        t_result w;
        logic    done;
        logic    ok;
        t_hunt   nxt;
        if (in_pay) begin
            done = (pay_cnt >= CNT_W'(PAYLOAD_BYTES - 1));
            if (hdr_ok) begin
                w.payload_byte    = b;
                w.station_id      = station;
                w.first_of_record = (pay_cnt == '0);
                w.last_of_record  = done;
                w.after_resync    = by_hunt;
                expected_words.push_back(w);
            end
            if (done) begin
                in_pay  = 1'b0;
                pay_cnt = '0;
                hdr_pos = HDR_CR;
                if (hdr_ok) begin
                    locked = 1'b1;
                end else begin
                    locked  = 1'b0;
                    hunt_st = HUNT_NONE;
                end
                hdr_ok = 1'b1;
            end else begin
                pay_cnt = pay_cnt + 1'b1;
            end
        end else if (!locked) begin
            if ((hunt_st == HUNT_ZERO) && (b != CH_CR)) begin
                station = station_of(b);
            end
            nxt = HUNT_NONE;
            if (b == CH_CR) begin
                nxt = HUNT_CR;
            end else if ((hunt_st == HUNT_CR) && (b == CH_LF)) begin
                nxt = HUNT_LF;
            end else if ((hunt_st == HUNT_LF) && (b == CH_ZERO)) begin
                nxt = HUNT_ZERO;
            end else if ((hunt_st == HUNT_ZERO) && (station != 6'd0)) begin
                nxt = HUNT_STATION;
            end else if ((hunt_st == HUNT_STATION) && tail_byte(b)) begin
                in_pay  = 1'b1;
                pay_cnt = '0;
                hdr_ok  = 1'b1;
                by_hunt = 1'b1;
            end
            hunt_st = nxt;
        end else begin
            if (hdr_pos == HDR_STATION) begin
                station = station_of(b);
            end
            case (hdr_pos)
                HDR_CR:      ok = (b == CH_CR);
                HDR_LF:      ok = (b == CH_LF);
                HDR_ZERO:    ok = (b == CH_ZERO);
                HDR_STATION: ok = (station != 6'd0);
                default:     ok = tail_byte(b);
            endcase
            if (!ok) begin
                hdr_ok = 1'b0;
            end
            if (hdr_pos >= HDR_TAIL) begin
                hdr_pos = HDR_CR;
                in_pay  = 1'b1;
                pay_cnt = '0;
                by_hunt = 1'b0;
            end else begin
                hdr_pos = hdr_pos + 1'b1;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            expected_words.delete();
            locked  = 1'b0;
            hunt_st = HUNT_NONE;
            hdr_pos = HDR_CR;
            hdr_ok  = 1'b1;
            pay_cnt = '0;
            in_pay  = 1'b0;
            station = 6'd0;
            by_hunt = 1'b0;
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual byte %0d station %0d",
                             $time, i_payload_byte, i_station_id);
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("payload_byte", int'(w.payload_byte), int'(i_payload_byte));
                    check_field("station_id", int'(w.station_id), int'(i_station_id));
                    check_field("first_of_record", int'(w.first_of_record),
                                int'(i_first_of_record));
                    check_field("last_of_record", int'(w.last_of_record),
                                int'(i_last_of_record));
                    check_field("after_resync", int'(w.after_resync), int'(i_after_resync));
                    o_words_checked++;
                end
            end
            if (i_push && !i_full) begin
                frame_byte(i_rx_byte);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

@@ dv/tracker_record_framer_top_tb.sv @@
// Testbench top for the tracker record framer: byte stimulus, result stalls and verdict.
module tracker_record_framer_top_tb;
    import trf_pkg::*;

    localparam int ITEMS = 1300;
    localparam int LIMIT = 400000;
    localparam int DRAIN = 8;

    localparam int BREAK_NONE = -1;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic       pop       = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       full;
    logic       empty;
    logic [7:0] o_payload_byte;
    logic [5:0] o_station_id;
    logic       o_first_of_record;
    logic       o_last_of_record;
    logic       o_after_resync;

    int fail_count;
    int pending;
    int words_checked;
    int cycles     = 0;
    int bytes_sent = 0;
    int records    = 0;
    int pop_hold   = 0;
    bit send_steady = 1'b0;
    bit pop_steady  = 1'b0;

    tracker_record_framer_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_rx_byte         (i_rx_byte),
        .empty             (empty),
        .pop               (pop),
        .o_payload_byte    (o_payload_byte),
        .o_station_id      (o_station_id),
        .o_first_of_record (o_first_of_record),
        .o_last_of_record  (o_last_of_record),
        .o_after_resync    (o_after_resync)
    );

    tracker_record_framer_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_rx_byte         (i_rx_byte),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_payload_byte    (o_payload_byte),
        .i_station_id      (o_station_id),
        .i_first_of_record (o_first_of_record),
        .i_last_of_record  (o_last_of_record),
        .i_after_resync    (o_after_resync),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_words_checked   (words_checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("tracker_record_framer_top_tb: errors");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 1;
        end else if (r < 90) begin
            return $urandom_range(2, 4);
        end else if (r < 97) begin
            return $urandom_range(5, 12);
        end
        return $urandom_range(25, 60);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop = 1'b0;
        end else if (pop_hold > 0) begin
            pop = 1'b0;
            pop_hold--;
        end else begin
            pop = 1'b1;
            if (!pop_steady && ($urandom_range(0, 99) < 25)) begin
                pop_hold = idle_len();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!send_steady && ($urandom_range(0, 99) >= 60)) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] station_char();
        case ($urandom_range(0, 2))
            0:       return CH_ONE + 8'($urandom_range(0, 8));
            1:       return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_LA + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] tail_char();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_UA + 8'($urandom_range(0, 25));
            default: return CH_LA + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] bad_station_char();
        logic [7:0] pick[10] = '{8'h00, 8'h2F, CH_ZERO, 8'h3A, 8'h40,
                                 8'h5B, 8'h60, 8'h7B, 8'hFF, CH_CR};
        return pick[$urandom_range(0, 9)];
    endfunction

    function automatic logic [7:0] bad_tail_char();
        logic [7:0] pick[9] = '{8'h00, 8'h1F, 8'h21, 8'h40, 8'h5B,
                                8'h60, 8'h7B, 8'hFF, CH_CR};
        return pick[$urandom_range(0, 8)];
    endfunction

    function automatic logic [7:0] payload_fill();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return 8'h00;
        end else if (r < 20) begin
            return 8'hFF;
        end else if (r < 25) begin
            return CH_CR;
        end else if (r < 28) begin
            return CH_LF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_header(input int broken_at, input int upto);
        logic [7:0] hdr[5];
        hdr[0] = CH_CR;
        hdr[1] = CH_LF;
        hdr[2] = CH_ZERO;
        hdr[3] = station_char();
        hdr[4] = tail_char();
        case (broken_at)
            0:       hdr[0] = CH_CR ^ (8'h1 << $urandom_range(0, 7));
            1:       hdr[1] = CH_LF ^ (8'h1 << $urandom_range(0, 7));
            2:       hdr[2] = CH_ZERO ^ (8'h1 << $urandom_range(0, 7));
            3:       hdr[3] = bad_station_char();
            4:       hdr[4] = bad_tail_char();
            default: ;
        endcase
        for (int i = 0; i < upto; i++) begin
            send_byte(hdr[i]);
        end
    endtask

    task automatic send_record(input int broken_at);
        send_header(broken_at, 5);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            send_byte(payload_fill());
        end
        records++;
    endtask

    initial begin
        int  r;
        bit  paused;
        logic [7:0] opening[26] = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_CR, CH_LF, CH_ZERO,
                                    CH_CR, CH_LF, CH_ZERO, 8'h42, CH_CR, CH_LF, CH_ZERO,
                                    8'h3A, CH_CR, CH_LF, CH_ZERO, 8'h35, 8'h21,
                                    CH_CR, CH_LF, CH_ZERO, 8'h7A, CH_SPACE, 8'h00};
        paused = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // restart on CR at the LF, zero and station match depths, reject bad station and tail, then lock
        foreach (opening[i]) begin
            send_byte(opening[i]);
        end
        send_byte(8'hFF);
        for (int i = 2; i < PAYLOAD_BYTES; i++) begin
            send_byte(payload_fill());
        end
        send_record(BREAK_NONE);
        send_record(3);
        send_record(BREAK_NONE);
        send_record(BREAK_NONE);
        wait_drained();

        while (bytes_sent < ITEMS) begin
            if ($urandom_range(0, 12) == 0) begin
                send_steady = !send_steady;
            end
            if ($urandom_range(0, 12) == 0) begin
                pop_steady = !pop_steady;
            end
            if (!paused && (bytes_sent >= ITEMS / 2)) begin
                wait_drained();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 68) begin
                send_record(BREAK_NONE);
            end else if (r < 80) begin
                send_record($urandom_range(0, 4));
            end else if (r < 90) begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_header(BREAK_NONE, $urandom_range(1, 4));
                if ($urandom_range(0, 1) == 1) begin
                    send_byte(CH_CR);
                end
            end
        end

        push        = 1'b0;
        pop_steady  = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("sent %0d bytes in %0d generated records plus noise and broken headers",
                 bytes_sent, records);
        $display("checked %0d payload words under random sender gaps and receiver stalls",
                 words_checked);
        if (fail_count == 0) begin
            $display("tracker_record_framer_top_tb: clean");
        end else begin
            $display("tracker_record_framer_top_tb: errors");
        end
        $finish;
    end

endmodule
